// ----- rtl/modbus_rtu_response_deframer_unit_defines.svh -----
// Assertion macros for the response deframer.
// Depends on nothing; the including module must have clk and rst_n in scope.
`ifndef MODBUS_RTU_RESPONSE_DEFRAMER_UNIT_DEFINES_SVH
`define MODBUS_RTU_RESPONSE_DEFRAMER_UNIT_DEFINES_SVH

// same-cycle implication
`define MRD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MRD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/mrd_pkg.sv -----
// Shared types, constants and the CRC-16 byte step for the response deframer.
// Depends on nothing.
`default_nettype none
package mrd_pkg;

  localparam logic [7:0] FN_WRITE_SINGLE = 8'h06;
  localparam logic [7:0] FN_WRITE_MULTI  = 8'h10;
  localparam logic [7:0] FN_READ_HOLD    = 8'h03;
  localparam int         EXC_BIT         = 7;
  localparam int         RUN_BIT         = 2;
  localparam logic [7:0] POS_BYTES       = 8'h04;
  localparam logic [7:0] MAX_COUNT       = 8'd250;
  localparam logic [7:0] MIN_FRAME       = 8'd5;
  localparam logic [7:0] ECHO_LEN        = 8'd8;
  localparam logic [7:0] STATUS_MIN_LEN  = 8'd7;
  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [15:0] CRC_POLY       = 16'hA001;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_STATUS,
    KIND_POS
  } kind_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    kind_t      kind;
  } item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ADDR,
    ST_FN,
    ST_CNT,
    ST_LEN,
    ST_CRC,
    ST_RC0,
    ST_RC1,
    ST_DATA,
    ST_DONE
  } state_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/modbus_rtu_response_deframer_unit.sv -----
// Modbus RTU response deframer, top level: config register, front queue, scan engine.
// Depends on mrd_pkg, mrd_front, mrd_back and the defines header.
//
// Usage:
//   in_*  : one received serial byte per word; tdata = rx_byte, tuser = expect_kind.
//   out_* : exactly one result word per input word, in order.
//   cfg_* : writes the slave address; always ready; write only while idle.
// Operation:
//   Each byte is appended to a ring buffer and the buffer is rescanned from its start.
//   A rejected start byte is skipped; a candidate frame is checked byte by byte through
//   the single read port feeding the bytewise CRC unit, and a decoded reply is then
//   read out. The next byte is taken from the queue only after the result is registered.
//   A two-entry queue accepts bytes while the engine scans.
// Reset:
//   Buffer empties, slave address returns to 1, queue and result valid clear.
//   No clearing pass is run.
// Stall:
//   The result is held in the output register until out_tready; the engine
//   then waits, the queue fills and in_tready drops.
`default_nettype none
`include "modbus_rtu_response_deframer_unit_defines.svh"
module modbus_rtu_response_deframer_unit
  import mrd_pkg::*;
#(
  parameter int BUF_BYTES = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  wire logic [1:0]  in_tuser,   // [1:0] expect_kind
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [0] echo_seen, [1] status_valid, [17:2] status_word, [18] running_seen,
  // [19] position_valid, [51:20] position, [55:52] zero
  output logic [55:0]      out_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_data
);

  logic [7:0]  slave_addr_r;
  logic        q_valid, q_pop;
  item_t       q_item;
  logic        echo_seen, status_valid, running_seen, position_valid;
  logic [15:0] status_word;
  logic [31:0] position;
  logic [$clog2(BUF_BYTES+1)-1:0] fill_level;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_addr_r <= 8'd1;
    end else if (cfg_valid) begin
      slave_addr_r <= cfg_data;
    end
  end

  mrd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_byte  (in_tdata),
    .in_kind  (in_tuser),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  mrd_back #(
    .BUF_BYTES (BUF_BYTES)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .slave_address  (slave_addr_r),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .echo_seen      (echo_seen),
    .status_valid   (status_valid),
    .status_word    (status_word),
    .running_seen   (running_seen),
    .position_valid (position_valid),
    .position       (position),
    .fill_level     (fill_level)
  );

  assign out_tdata = {4'd0, position, position_valid, running_seen, status_word,
                      status_valid, echo_seen};

  `MRD_ASSERT_NOW(a_fill_bound, 1'b1, fill_level <= ($clog2(BUF_BYTES+1))'(BUF_BYTES), "buffer fill above depth")
  `MRD_ASSERT_NOW(a_status_zero, out_tvalid && !status_valid, status_word == 16'd0 && !running_seen, "status fields set without status reply")
  `MRD_ASSERT_NOW(a_pos_zero, out_tvalid && !position_valid, position == 32'd0, "position set without position reply")

endmodule
`default_nettype wire

// ----- rtl/mrd_front.sv -----
// Input side: takes bytes, classifies the awaited reply kind, holds a two-entry queue.
// Depends on mrd_pkg.
`default_nettype none
module mrd_front
  import mrd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic [1:0] in_kind,
  output logic            q_valid,
  output item_t           q_item,
  input  wire logic       q_pop
);

  item_t      ent0_r, ent0_nxt, ent1_r, ent1_nxt;
  logic [1:0] fill_r, fill_nxt;
  item_t      cls;
  logic       push;

  always_comb begin
    cls.rx_byte = in_byte;
    case (in_kind)
      2'd1:    cls.kind = KIND_STATUS;
      2'd2:    cls.kind = KIND_POS;
      default: cls.kind = KIND_NONE;
    endcase
  end

  assign in_ready = (fill_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (fill_r != 2'd0);
  assign q_item   = ent0_r;

  always_comb begin
    ent0_nxt = ent0_r;
    ent1_nxt = ent1_r;
    fill_nxt = fill_r;
    if (q_pop && q_valid) begin
      ent0_nxt = ent1_r;
      fill_nxt = fill_nxt - 2'd1;
    end
    if (push) begin
      if (fill_nxt == 2'd0) begin
        ent0_nxt = cls;
      end else begin
        ent1_nxt = cls;
      end
      fill_nxt = fill_nxt + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= 2'd0;
    end else begin
      fill_r <= fill_nxt;
    end
    ent0_r <= ent0_nxt;
    ent1_r <= ent1_nxt;
  end

endmodule
`default_nettype wire

// ----- rtl/mrd_back.sv -----
// Scan engine: ring buffer memory, frame search with bytewise CRC-16, result register.
// Depends on mrd_pkg.
`default_nettype none
module mrd_back
  import mrd_pkg::*;
#(
  parameter int BUF_BYTES = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [7:0]  slave_address,
  input  wire logic        q_valid,
  input  wire item_t       q_item,
  output logic             q_pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             echo_seen,
  output logic             status_valid,
  output logic [15:0]      status_word,
  output logic             running_seen,
  output logic             position_valid,
  output logic [31:0]      position,
  output logic [$clog2(BUF_BYTES+1)-1:0] fill_level
);

  localparam int AW = $clog2(BUF_BYTES);
  localparam int CW = $clog2(BUF_BYTES + 1);
  localparam int SW = ($clog2(2 * BUF_BYTES) > 8) ? $clog2(2 * BUF_BYTES) : 9;

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [SW-1:0] b);
    logic [SW-1:0] s;
    s = SW'(a) + b;
    if (s >= SW'(BUF_BYTES)) s = s - SW'(BUF_BYTES);
    return s[AW-1:0];
  endfunction

  logic [7:0] mem [BUF_BYTES];
  logic [7:0] rd_data_r;

  state_t        state_r, state_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  kind_t         kind_r, kind_nxt;
  logic [7:0]    fn_r, fn_nxt, cnt_r, cnt_nxt, len_r, len_nxt, idx_r, idx_nxt;
  logic [15:0]   crc_r, crc_nxt;
  logic          rc0_ok_r, rc0_ok_nxt, pmode_r, pmode_nxt;
  logic [2:0]    dleft_r, dleft_nxt;
  logic [31:0]   acc_r, acc_nxt;
  logic          echo_r, echo_nxt, st_ok_r, st_ok_nxt, run_r, run_nxt, pos_ok_r, pos_ok_nxt;
  logic [15:0]   status_r, status_nxt;
  logic [31:0]   pos_r, pos_nxt;

  logic          ov_r, ov_nxt;
  logic          o_echo_r, o_echo_nxt, o_st_r, o_st_nxt, o_run_r, o_run_nxt;
  logic          o_pos_ok_r, o_pos_ok_nxt;
  logic [15:0]   o_status_r, o_status_nxt;
  logic [31:0]   o_pos_r, o_pos_nxt;

  logic [AW-1:0] rd_rel, raddr, waddr, base;
  logic          we;
  logic          adv_en;
  logic [7:0]    adv;

  assign raddr = wrap_add(head_r, SW'(rd_rel));
  assign base  = (count_r == CW'(BUF_BYTES)) ? wrap_add(head_r, SW'(1)) : head_r;
  assign waddr = wrap_add(base, (count_r == CW'(BUF_BYTES)) ? SW'(BUF_BYTES - 1) : SW'(count_r));

  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    count_nxt    = count_r;
    kind_nxt     = kind_r;
    fn_nxt       = fn_r;
    cnt_nxt      = cnt_r;
    len_nxt      = len_r;
    idx_nxt      = idx_r;
    crc_nxt      = crc_r;
    rc0_ok_nxt   = rc0_ok_r;
    pmode_nxt    = pmode_r;
    dleft_nxt    = dleft_r;
    acc_nxt      = acc_r;
    echo_nxt     = echo_r;
    st_ok_nxt    = st_ok_r;
    run_nxt      = run_r;
    pos_ok_nxt   = pos_ok_r;
    status_nxt   = status_r;
    pos_nxt      = pos_r;
    ov_nxt       = ov_r && !out_ready;
    o_echo_nxt   = o_echo_r;
    o_st_nxt     = o_st_r;
    o_run_nxt    = o_run_r;
    o_pos_ok_nxt = o_pos_ok_r;
    o_status_nxt = o_status_r;
    o_pos_nxt    = o_pos_r;
    rd_rel       = '0;
    we           = 1'b0;
    q_pop        = 1'b0;
    adv_en       = 1'b0;
    adv          = 8'd1;

    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          we         = 1'b1;
          kind_nxt   = q_item.kind;
          head_nxt   = base;
          count_nxt  = (count_r == CW'(BUF_BYTES)) ? count_r : count_r + CW'(1);
          echo_nxt   = 1'b0;
          st_ok_nxt  = 1'b0;
          run_nxt    = 1'b0;
          pos_ok_nxt = 1'b0;
          status_nxt = '0;
          pos_nxt    = '0;
          state_nxt  = ST_CHECK;
        end
      end
      ST_CHECK: begin
        rd_rel = '0;
        if (SW'(count_r) < SW'(MIN_FRAME)) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_ADDR;
        end
      end
      ST_ADDR: begin
        rd_rel = AW'(1);
        if (rd_data_r != slave_address) begin
          adv_en = 1'b1;
        end else begin
          state_nxt = ST_FN;
        end
      end
      ST_FN: begin
        fn_nxt = rd_data_r;
        rd_rel = AW'(2);
        if (rd_data_r == FN_WRITE_SINGLE || rd_data_r == FN_WRITE_MULTI) begin
          len_nxt   = ECHO_LEN;
          state_nxt = ST_LEN;
        end else if (rd_data_r == FN_READ_HOLD) begin
          state_nxt = ST_CNT;
        end else if (rd_data_r[EXC_BIT]) begin
          len_nxt   = MIN_FRAME;
          state_nxt = ST_LEN;
        end else begin
          adv_en = 1'b1;
        end
      end
      ST_CNT: begin
        cnt_nxt = rd_data_r;
        if (rd_data_r > MAX_COUNT) begin
          adv_en = 1'b1;
        end else begin
          len_nxt   = MIN_FRAME + rd_data_r;
          state_nxt = ST_LEN;
        end
      end
      ST_LEN: begin
        rd_rel = '0;
        if (SW'(count_r) < SW'(len_r)) begin
          state_nxt = ST_DONE;
        end else begin
          crc_nxt   = CRC_INIT;
          idx_nxt   = '0;
          state_nxt = ST_CRC;
        end
      end
      ST_CRC: begin
        crc_nxt = crc_byte(crc_r, rd_data_r);
        idx_nxt = idx_r + 8'd1;
        rd_rel  = AW'(idx_r + 8'd1);
        if (idx_r + 8'd1 == len_r - 8'd2) begin
          state_nxt = ST_RC0;
        end
      end
      ST_RC0: begin
        rc0_ok_nxt = (rd_data_r == crc_r[7:0]);
        rd_rel     = AW'(len_r - 8'd1);
        state_nxt  = ST_RC1;
      end
      ST_RC1: begin
        rd_rel = AW'(3);
        if (!(rc0_ok_r && rd_data_r == crc_r[15:8])) begin
          adv_en = 1'b1;
        end else if (fn_r == FN_WRITE_SINGLE) begin
          echo_nxt = 1'b1;
          adv_en   = 1'b1;
          adv      = len_r;
        end else if (fn_r == FN_READ_HOLD && len_r >= STATUS_MIN_LEN &&
                     kind_r == KIND_STATUS) begin
          pmode_nxt = 1'b0;
          dleft_nxt = 3'd2;
          idx_nxt   = 8'd3;
          state_nxt = ST_DATA;
        end else if (fn_r == FN_READ_HOLD && kind_r == KIND_POS && cnt_r == POS_BYTES) begin
          pmode_nxt = 1'b1;
          dleft_nxt = 3'd4;
          idx_nxt   = 8'd3;
          state_nxt = ST_DATA;
        end else begin
          adv_en = 1'b1;
          adv    = len_r;
        end
      end
      ST_DATA: begin
        acc_nxt   = {acc_r[23:0], rd_data_r};
        idx_nxt   = idx_r + 8'd1;
        rd_rel    = AW'(idx_r + 8'd1);
        dleft_nxt = dleft_r - 3'd1;
        if (dleft_r == 3'd1) begin
          if (pmode_r) begin
            pos_nxt    = {acc_r[23:0], rd_data_r};
            pos_ok_nxt = 1'b1;
          end else begin
            status_nxt = {acc_r[7:0], rd_data_r};
            st_ok_nxt  = 1'b1;
            run_nxt    = run_r | rd_data_r[RUN_BIT];
          end
          adv_en = 1'b1;
          adv    = len_r;
        end
      end
      ST_DONE: begin
        if (!ov_r || out_ready) begin
          ov_nxt       = 1'b1;
          o_echo_nxt   = echo_r;
          o_st_nxt     = st_ok_r;
          o_run_nxt    = run_r;
          o_pos_ok_nxt = pos_ok_r;
          o_status_nxt = st_ok_r ? status_r : '0;
          o_pos_nxt    = pos_ok_r ? pos_r : '0;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (adv_en) begin
      head_nxt  = wrap_add(head_r, SW'(adv));
      count_nxt = count_r - CW'(adv);
      state_nxt = ST_CHECK;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= q_item.rx_byte;
    end
    rd_data_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      head_r  <= '0;
      count_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
      ov_r    <= ov_nxt;
    end
    kind_r     <= kind_nxt;
    fn_r       <= fn_nxt;
    cnt_r      <= cnt_nxt;
    len_r      <= len_nxt;
    idx_r      <= idx_nxt;
    crc_r      <= crc_nxt;
    rc0_ok_r   <= rc0_ok_nxt;
    pmode_r    <= pmode_nxt;
    dleft_r    <= dleft_nxt;
    acc_r      <= acc_nxt;
    echo_r     <= echo_nxt;
    st_ok_r    <= st_ok_nxt;
    run_r      <= run_nxt;
    pos_ok_r   <= pos_ok_nxt;
    status_r   <= status_nxt;
    pos_r      <= pos_nxt;
    o_echo_r   <= o_echo_nxt;
    o_st_r     <= o_st_nxt;
    o_run_r    <= o_run_nxt;
    o_pos_ok_r <= o_pos_ok_nxt;
    o_status_r <= o_status_nxt;
    o_pos_r    <= o_pos_nxt;
  end

  assign out_valid      = ov_r;
  assign echo_seen      = o_echo_r;
  assign status_valid   = o_st_r;
  assign status_word    = o_status_r;
  assign running_seen   = o_run_r;
  assign position_valid = o_pos_ok_r;
  assign position       = o_pos_r;
  assign fill_level     = count_r;

endmodule
`default_nettype wire
